// ----- rtl/spm_pkg.sv -----
// Shared types, sizes and codes for the sparse polynomial multiplier.
// Used by the channel interfaces, the two memories and the top level.
package spm_pkg;

  // Sizing of the term store and the product memory
  localparam int MAX_TERMS  = 32;
  localparam int MAX_EXP    = 31;
  localparam int COEFF_BITS = 16;
  localparam int PROD_DEPTH = 2 * MAX_EXP + 1;

  // Field widths of the channels
  localparam int OP_W     = 2;
  localparam int IN_C_W   = 16;
  localparam int EXP_W    = 5;
  localparam int ACC_W    = 32;
  localparam int REXP_W   = 6;

  localparam int TIDX_W  = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int TCNT_W  = $clog2(MAX_TERMS + 1);
  localparam int PADDR_W = $clog2(PROD_DEPTH);

  typedef logic        [OP_W-1:0]       op_t;
  typedef logic signed [IN_C_W-1:0]     in_coeff_t;
  typedef logic        [EXP_W-1:0]      exp_t;
  typedef logic signed [COEFF_BITS-1:0] coeff_t;
  typedef logic signed [ACC_W-1:0]      acc_t;
  typedef logic        [REXP_W-1:0]     rexp_t;
  typedef logic        [TIDX_W-1:0]     tidx_t;
  typedef logic        [TCNT_W-1:0]     tcnt_t;
  typedef logic        [PADDR_W-1:0]    paddr_t;
  typedef logic        [PROD_DEPTH-1:0] prod_vec_t;

  // Operation codes carried by an input beat
  typedef enum logic [OP_W-1:0] {
    OP_LOAD = 2'd0,
    OP_MUL  = 2'd1,
    OP_EMIT = 2'd2
  } op_e;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SCAN,
    ST_WAIT,
    ST_EMPTY
  } state_e;

  // One stored first-polynomial term
  typedef struct packed {
    coeff_t coeff;
    exp_t   exp;
  } term_t;

  // Write port of the term store
  typedef struct packed {
    logic   en;
    tidx_t  addr;
    term_t  data;
  } term_wr_t;

  // Write port of the product memory
  typedef struct packed {
    logic   en;
    paddr_t addr;
    acc_t   data;
  } prod_wr_t;

endpackage

// ----- rtl/spm_if.sv -----
// Valid/ready channel interfaces for the sparse polynomial multiplier.
// Depends on spm_pkg for field types.
interface spm_in_if;
  logic               valid;
  logic               ready;
  spm_pkg::op_t       operation;
  spm_pkg::in_coeff_t coeff;
  spm_pkg::exp_t      exp;

  modport source (output valid, output operation, output coeff, output exp, input ready);
  modport sink   (input valid, input operation, input coeff, input exp, output ready);
endinterface

interface spm_out_if;
  logic          valid;
  logic          ready;
  spm_pkg::acc_t  result_coeff;
  spm_pkg::rexp_t result_exp;
  logic          valid_res;
  logic          last;

  modport source (output valid, output result_coeff, output result_exp,
                  output valid_res, output last, input ready);
  modport sink   (input valid, input result_coeff, input result_exp,
                  input valid_res, input last, output ready);
endinterface

// ----- rtl/spm_term_store.sv -----
// Term store: first-polynomial coefficients and exponents, one write and
// one registered read per cycle. Depends on spm_pkg.
module spm_term_store (
  input  logic              clk_i,
  input  spm_pkg::term_wr_t wr_i,
  input  spm_pkg::tidx_t    rd_addr_i,
  output spm_pkg::term_t    rd_data_o
);

  spm_pkg::term_t mem_q [spm_pkg::MAX_TERMS];
  spm_pkg::term_t rd_q;

  // Write the loaded term, read the walked term
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    rd_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_q;

endmodule

// ----- rtl/spm_prod_mem.sv -----
// Product memory: accumulated coefficients with per-entry present flags.
// Absent entries read as zero; a read of the entry written in the same
// cycle returns the new value. Depends on spm_pkg.
module spm_prod_mem (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  spm_pkg::prod_wr_t   wr_i,
  input  logic                clr_i,
  input  spm_pkg::paddr_t     rd_addr_i,
  output spm_pkg::acc_t       rd_data_o,
  output spm_pkg::prod_vec_t  present_o
);

  spm_pkg::acc_t      mem_q [spm_pkg::PROD_DEPTH];
  spm_pkg::acc_t      rd_q;
  spm_pkg::acc_t      fwd_data_q;
  spm_pkg::prod_vec_t present_q;
  logic               fwd_q;
  logic               rd_pres_q;

  // Storage array and forwarded write data
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    rd_q       <= mem_q[rd_addr_i];
    fwd_data_q <= wr_i.data;
  end

  // Present flags: set on write, drop all on clear
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q <= '0;
      fwd_q     <= 1'b0;
      rd_pres_q <= 1'b0;
    end else begin
      fwd_q     <= wr_i.en && (wr_i.addr == rd_addr_i);
      rd_pres_q <= present_q[rd_addr_i];
      if (clr_i) begin
        present_q <= '0;
      end else if (wr_i.en) begin
        present_q[wr_i.addr] <= 1'b1;
      end
    end
  end

  assign rd_data_o = fwd_q ? fwd_data_q : (rd_pres_q ? rd_q : '0);
  assign present_o = present_q;

endmodule

// ----- rtl/sparse_polynomial_multiplier_top.sv -----
// Sparse polynomial multiplier, top level: sequencer, multiply pipeline and
// output register. Depends on spm_pkg, spm_if, spm_term_store, spm_prod_mem.
//
// Load beats store a first-polynomial term (up to 32 terms, further loads
// are dropped). A multiply beat walks the stored terms through the
// three-stage pipeline of term read, multiply and accumulate, one
// read-modify-write of the product memory per term, and holds off new beats
// until its last accumulate is written; with an empty store it does no walk.
// An emit beat scans the product slots from the highest exponent down to the
// lowest present one, one slot per cycle, pausing at each present term to
// load its result beat and while the sink holds ready low; with the final
// beat it clears both stores. An emit with no present term returns one beat
// with valid_res low and last high. No clearing pass is needed after reset.
module sparse_polynomial_multiplier_top (
  input logic       clk_i,
  input logic       rst_ni,
  spm_in_if.sink    in_i,
  spm_out_if.source out_o
);

  spm_pkg::state_e    state_q, state_d;
  spm_pkg::tidx_t     idx_q, idx_d;
  spm_pkg::tcnt_t     cnt_q, cnt_d;
  spm_pkg::paddr_t    k_q, k_d;
  spm_pkg::exp_t      e_q;
  spm_pkg::acc_t      c_q;
  logic               v1_q, v1_d;
  logic               v2_q, v2_d;
  spm_pkg::paddr_t    s2_q;
  spm_pkg::acc_t      p2_q;

  logic               out_vld_q;
  spm_pkg::acc_t      out_coeff_q;
  spm_pkg::rexp_t     out_exp_q;
  logic               out_vres_q;
  logic               out_last_q;

  logic               accept;
  logic               out_free;
  logic               out_load;
  logic               out_vres_d;
  logic               out_last_d;
  logic               clr;
  logic               cap;

  spm_pkg::term_wr_t  term_wr;
  spm_pkg::term_t     term_rd;
  spm_pkg::prod_wr_t  prod_wr;
  spm_pkg::paddr_t    prod_raddr;
  spm_pkg::acc_t      prod_rdata;
  spm_pkg::prod_vec_t present;
  spm_pkg::prod_vec_t below_mask;
  spm_pkg::paddr_t    s1;
  logic               hit1;
  logic               last_w;
  spm_pkg::acc_t      a32;

  assign accept   = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == spm_pkg::ST_IDLE) && !v1_q && !v2_q;
  assign out_free = !out_vld_q || out_o.ready;

  // Slots strictly below the scan pointer
  assign below_mask = (spm_pkg::prod_vec_t'(1) << k_q) - spm_pkg::prod_vec_t'(1);
  assign last_w     = (present & below_mask) == '0;

  // Load write into the term store
  always_comb begin
    term_wr            = '0;
    term_wr.addr       = spm_pkg::tidx_t'(cnt_q);
    term_wr.data.coeff = in_i.coeff[spm_pkg::COEFF_BITS-1:0];
    term_wr.data.exp   = in_i.exp;
    term_wr.en         = accept && (spm_pkg::op_e'(in_i.operation) == spm_pkg::OP_LOAD)
                         && (in_i.exp <= spm_pkg::exp_t'(spm_pkg::MAX_EXP))
                         && (cnt_q < spm_pkg::tcnt_t'(spm_pkg::MAX_TERMS));
  end

  spm_term_store u_term_store (
    .clk_i     (clk_i),
    .wr_i      (term_wr),
    .rd_addr_i (idx_q),
    .rd_data_o (term_rd)
  );

  // Stage one: exponent sum and product of the walked term
  assign s1   = spm_pkg::paddr_t'(term_rd.exp) + spm_pkg::paddr_t'(e_q);
  assign hit1 = s1 <= spm_pkg::paddr_t'(spm_pkg::PROD_DEPTH - 1);
  assign a32  = spm_pkg::acc_t'(term_rd.coeff);
  assign v2_d = v1_q && hit1;

  always_ff @(posedge clk_i) begin
    s2_q <= s1;
    p2_q <= a32 * c_q;
  end

  // Stage two: accumulate and write back
  always_comb begin
    prod_wr      = '0;
    prod_wr.en   = v2_q;
    prod_wr.addr = s2_q;
    prod_wr.data = prod_rdata + p2_q;
  end

  assign prod_raddr = (state_q == spm_pkg::ST_MUL || v1_q) ? s1 : k_q;

  spm_prod_mem u_prod_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (prod_wr),
    .clr_i     (clr),
    .rd_addr_i (prod_raddr),
    .rd_data_o (prod_rdata),
    .present_o (present)
  );

  // Sequencer registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= spm_pkg::ST_IDLE;
      idx_q   <= '0;
      cnt_q   <= '0;
      k_q     <= '0;
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      cnt_q   <= cnt_d;
      k_q     <= k_d;
      v1_q    <= v1_d;
      v2_q    <= v2_d;
    end
  end

  // Hold the multiplier term of the current beat
  always_ff @(posedge clk_i) begin
    if (cap) begin
      e_q <= in_i.exp;
      c_q <= spm_pkg::acc_t'(spm_pkg::coeff_t'(in_i.coeff[spm_pkg::COEFF_BITS-1:0]));
    end
  end

  // Next state and control
  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    cnt_d      = cnt_q;
    k_d        = k_q;
    v1_d       = 1'b0;
    cap        = 1'b0;
    clr        = 1'b0;
    out_load   = 1'b0;
    out_vres_d = 1'b1;
    out_last_d = 1'b0;
    case (state_q)
      spm_pkg::ST_IDLE: begin
        if (accept) begin
          case (spm_pkg::op_e'(in_i.operation))
            spm_pkg::OP_LOAD: begin
              if (term_wr.en) begin
                cnt_d = cnt_q + spm_pkg::tcnt_t'(1);
              end
            end
            spm_pkg::OP_MUL: begin
              cap   = 1'b1;
              idx_d = '0;
              if (in_i.exp <= spm_pkg::exp_t'(spm_pkg::MAX_EXP) && cnt_q != '0) begin
                state_d = spm_pkg::ST_MUL;
              end
            end
            spm_pkg::OP_EMIT: begin
              k_d     = spm_pkg::paddr_t'(spm_pkg::PROD_DEPTH - 1);
              state_d = (present != '0) ? spm_pkg::ST_SCAN : spm_pkg::ST_EMPTY;
            end
            default: begin
            end
          endcase
        end
      end
      spm_pkg::ST_MUL: begin
        v1_d  = 1'b1;
        idx_d = idx_q + spm_pkg::tidx_t'(1);
        if (spm_pkg::tcnt_t'(idx_q) == cnt_q - spm_pkg::tcnt_t'(1)) begin
          state_d = spm_pkg::ST_IDLE;
        end
      end
      spm_pkg::ST_SCAN: begin
        if (present[k_q]) begin
          if (out_free) begin
            state_d = spm_pkg::ST_WAIT;
          end
        end else begin
          k_d = k_q - spm_pkg::paddr_t'(1);
        end
      end
      spm_pkg::ST_WAIT: begin
        out_load   = 1'b1;
        out_last_d = last_w;
        if (last_w) begin
          clr     = 1'b1;
          cnt_d   = '0;
          state_d = spm_pkg::ST_IDLE;
        end else begin
          k_d     = k_q - spm_pkg::paddr_t'(1);
          state_d = spm_pkg::ST_SCAN;
        end
      end
      spm_pkg::ST_EMPTY: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_vres_d = 1'b0;
          out_last_d = 1'b1;
          clr        = 1'b1;
          cnt_d      = '0;
          state_d    = spm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = spm_pkg::ST_IDLE;
      end
    endcase
  end

  // Output register: load a result beat, drop it once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_load) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_coeff_q <= out_vres_d ? prod_rdata : '0;
      out_exp_q   <= out_vres_d ? spm_pkg::rexp_t'(k_q) : '0;
      out_vres_q  <= out_vres_d;
      out_last_q  <= out_last_d;
    end
  end

  assign out_o.valid        = out_vld_q;
  assign out_o.result_coeff = out_coeff_q;
  assign out_o.result_exp   = out_exp_q;
  assign out_o.valid_res    = out_vres_q;
  assign out_o.last         = out_last_q;

`ifndef NO_ASSERTIONS
  // The output register is free whenever a scanned slot arrives from memory
  a_wait_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == spm_pkg::ST_WAIT |-> !out_vld_q)
    else $error("result beat would overwrite a pending one");

  // The final beat of an emit leaves both stores empty
  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == spm_pkg::ST_WAIT && last_w) |=> (present == '0 && cnt_q == '0))
    else $error("stores not cleared after final emit beat");

  // The scan never runs below the lowest present slot
  a_scan_has_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == spm_pkg::ST_SCAN
      |-> (present & (below_mask | (spm_pkg::prod_vec_t'(1) << k_q))) != '0)
    else $error("emit scan has no present slot left");

  // Accumulation writes stay inside the product memory
  a_wr_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q |-> s2_q <= spm_pkg::paddr_t'(spm_pkg::PROD_DEPTH - 1))
    else $error("product write beyond memory depth");
`endif

endmodule
